>>> rtl/core/rna_pkg.sv
// Shared constants and controller/datapath interface types for the rolling NowCast block.
package rna_pkg;

  localparam int DEF_WINDOW_HOURS = 12;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int NOWCAST_W        = 16;
  localparam int Q_FRAC           = 16;
  localparam int Q_W              = Q_FRAC + 1;
  localparam logic [Q_W-1:0] Q_ONE  = 17'h10000;
  localparam logic [Q_W-1:0] Q_HALF = 17'h08000;

  typedef struct packed {
    logic load;
    logic scan;
    logic div1_init;
    logic div1_step;
    logic walk_mul;
    logic walk_acc;
    logic div2_init;
    logic div2_step;
    logic out_load;
    logic out_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic recent_ok;
    logic max_ok;
  } dp_status_t;

endpackage

>>> rtl/core/rolling_nowcast_average.sv
// Each input word runs through recency check, min/max scan, weight division, weighted walk and final division.
// Early exits (too few recent samples, zero maximum) go straight to the finish state.
// A word is taken only while idle, so a new word waits until the last result has been loaded.
// A new input word is taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) marks the whole window invalid and idles the block.
// Top level: 12-hour-style weighted NowCast over a rolling window of hourly samples.
module rolling_nowcast_average #(
  parameter int WINDOW_HOURS = rna_pkg::DEF_WINDOW_HOURS,
  parameter int SAMPLE_BITS  = rna_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        sample_value,
  input  logic                          sample_valid,
  input  logic                          series_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rna_pkg::NOWCAST_W-1:0] nowcast_value,
  output logic                          nowcast_valid
);
  import rna_pkg::*;

  dp_cmd_t                        cmd;
  dp_status_t                     status;
  logic [$clog2(WINDOW_HOURS)-1:0] idx;

  // Controller: accepts a word only when idle, then steps the datapath through
  // recency check, min/max scan, weight division, weighted walk and final division.
  rna_ctrl #(
    .WINDOW_HOURS(WINDOW_HOURS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx)
  );

  // Datapath: window shift line plus the arithmetic units; holds the result word.
  rna_dp #(
    .WINDOW_HOURS(WINDOW_HOURS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx          (idx),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .series_start (series_start),
    .status       (status),
    .nowcast_value(nowcast_value),
    .nowcast_valid(nowcast_valid)
  );

endmodule

>>> rtl/core/rna_dp.sv
// Datapath: sample window, min/max scan, weight divider, weighted walk, final divider.
module rna_dp #(
  parameter int WINDOW_HOURS = rna_pkg::DEF_WINDOW_HOURS,
  parameter int SAMPLE_BITS  = rna_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rna_pkg::dp_cmd_t                  cmd,
  input  logic [$clog2(WINDOW_HOURS)-1:0]   idx,
  input  logic [SAMPLE_BITS-1:0]            sample_value,
  input  logic                              sample_valid,
  input  logic                              series_start,
  output rna_pkg::dp_status_t               status,
  output logic [rna_pkg::NOWCAST_W-1:0]     nowcast_value,
  output logic                              nowcast_valid
);
  import rna_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int LW  = $clog2(WINDOW_HOURS);
  localparam int PSW = Q_W + LW;
  localparam int WSW = SB + PSW;
  localparam int DW  = WSW + 2;

  logic [SB-1:0]      val [WINDOW_HOURS];
  logic [WINDOW_HOURS-1:0] vld;
  logic [SB-1:0]      sel_val;
  logic               sel_vld;
  logic               any;
  logic [SB-1:0]      lo, hi;
  logic [SB:0]        rem1, r1;
  logic               ge1;
  logic [Q_W-1:0]     q1, w;
  logic [Q_W-1:0]     p, pacc;
  logic [2*Q_W-1:0]   pw;
  logic [SB+Q_W-1:0]  mprod, prod;
  logic [WSW-1:0]     wsum;
  logic [PSW-1:0]     psum;
  logic [DW-1:0]      dsum;
  logic [PSW:0]       dv, rem2;
  logic [PSW+1:0]     t2, r2;
  logic               ge2;
  logic [SB:0]        dlo, q2;
  logic [SB+NOWCAST_W:0] qx;

  assign sel_val = val[idx];
  assign sel_vld = vld[idx];

  assign status.recent_ok = (vld[0] & vld[1]) | (vld[0] & vld[2]) | (vld[1] & vld[2]);
  assign status.max_ok    = any && (hi != '0);

  // weight divider: quotient bit is known to sit at or below 2^16
  assign ge1 = rem1 >= {1'b0, hi};
  assign r1  = ge1 ? rem1 - {1'b0, hi} : rem1;
  assign w   = (q1 < Q_HALF) ? Q_HALF : q1;

  assign pw    = {{Q_W{1'b0}}, p} * {{Q_W{1'b0}}, w};
  assign mprod = (SB+Q_W)'(sel_val) * (SB+Q_W)'(p);

  assign dsum = {1'b0, wsum, 1'b0} + DW'(psum);
  assign dv   = {psum, 1'b0};
  assign t2   = {rem2, dlo[SB]};
  assign ge2  = t2 >= {1'b0, dv};
  assign r2   = ge2 ? t2 - {1'b0, dv} : t2;
  assign qx   = {{NOWCAST_W{1'b0}}, q2};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.load) begin
      vld[0] <= sample_valid;
      for (int k = 1; k < WINDOW_HOURS; k++) vld[k] <= series_start ? 1'b0 : vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val[0] <= sample_valid ? sample_value : '0;
      for (int k = 1; k < WINDOW_HOURS; k++) val[k] <= val[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (cmd.load) begin
      any <= 1'b0;
    end else if (cmd.scan && sel_vld) begin
      any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && sel_vld) begin
      if (!any || sel_val < lo) lo <= sel_val;
      if (!any || sel_val > hi) hi <= sel_val;
    end
    if (cmd.div1_init) begin
      rem1 <= {1'b0, lo};
      q1   <= '0;
    end else if (cmd.div1_step) begin
      rem1 <= {r1[SB-1:0], 1'b0};
      q1   <= {q1[Q_W-2:0], ge1};
    end
    prod <= (cmd.walk_mul && sel_vld) ? mprod : '0;
    pacc <= (cmd.walk_mul && sel_vld) ? p : '0;
    if (cmd.div1_init) begin
      p    <= Q_ONE;
      wsum <= '0;
      psum <= '0;
    end else begin
      if (cmd.walk_mul) p <= pw[Q_FRAC +: Q_W];
      if (cmd.walk_acc) begin
        wsum <= wsum + WSW'(prod);
        psum <= psum + PSW'(pacc);
      end
    end
    if (cmd.div2_init) begin
      rem2 <= dsum[DW-1:SB+1];
      dlo  <= dsum[SB:0];
      q2   <= '0;
    end else if (cmd.div2_step) begin
      rem2 <= r2[PSW:0];
      dlo  <= {dlo[SB-1:0], 1'b0};
      q2   <= {q2[SB-1:0], ge2};
    end
    if (cmd.out_load) begin
      nowcast_value <= cmd.out_ok ? qx[NOWCAST_W-1:0] : '0;
      nowcast_valid <= cmd.out_ok;
    end
  end

endmodule

>>> rtl/core/rna_ctrl.sv
// Controller: sequences load, scan, divisions and weighted walk; owns the handshakes.
module rna_ctrl #(
  parameter int WINDOW_HOURS = rna_pkg::DEF_WINDOW_HOURS,
  parameter int SAMPLE_BITS  = rna_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  rna_pkg::dp_status_t               status,
  output rna_pkg::dp_cmd_t                  cmd,
  output logic [$clog2(WINDOW_HOURS)-1:0]   idx
);
  import rna_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_HOURS + SAMPLE_BITS + 18);
  localparam int IW    = $clog2(WINDOW_HOURS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_CHKMAX = 4'd3;
  localparam logic [3:0] S_DIV1   = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_DINIT  = 4'd6;
  localparam logic [3:0] S_DIV2   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ok, ok_next;
  logic             out_free;

  assign in_stall = state != S_IDLE;
  assign idx      = cnt[IW-1:0];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + CNT_W'(1);
    ok_next    = ok;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (status.recent_ok) begin
          state_next = S_SCAN;
        end else begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt == CNT_W'(WINDOW_HOURS - 1)) state_next = S_CHKMAX;
      end
      S_CHKMAX: begin
        cnt_next = '0;
        if (status.max_ok) begin
          cmd.div1_init = 1'b1;
          state_next    = S_DIV1;
        end else begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end
      end
      S_DIV1: begin
        cmd.div1_step = 1'b1;
        if (cnt == CNT_W'(Q_W - 1)) begin
          cnt_next   = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_mul = cnt < CNT_W'(WINDOW_HOURS);
        cmd.walk_acc = 1'b1;
        if (cnt == CNT_W'(WINDOW_HOURS)) state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div2_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2_step = 1'b1;
        if (cnt == CNT_W'(SAMPLE_BITS)) begin
          ok_next    = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ok   = ok;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ok    <= ok_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("word raised outside finish state");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt < CNT_W'(WINDOW_HOURS))
    else $error("scan index out of window");
  a_load_check: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHECK)
    else $error("load not followed by recency check");
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result overwrote a waiting word");
`endif

endmodule
